@@ rtl/zwse_pkg.sv @@
// ----------------------------------------------------------------------------
// Zero-width stego encoder package
// Shared constants, the job record handed to the serializer, and the
// Base64 alphabet lookup.
// ----------------------------------------------------------------------------
package zwse_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_POS_W     = $clog2(MAX_KEY_BYTES);
    localparam int KEY_LEN_W     = 5;
    localparam int KEY_BITS      = 8 * MAX_KEY_BYTES;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_KEY_LEN  = 2'd2;

    localparam logic [23:0] CH_START = 24'hE281A0;
    localparam logic [23:0] CH_END   = 24'hE281A3;
    localparam logic [23:0] CH_ZERO  = 24'hE2808B;
    localparam logic [23:0] CH_ONE   = 24'hE2808C;
    localparam logic [7:0]  PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic        has_start;
        logic [31:0] chars;
        logic [5:0]  nbits;
        logic        has_end;
    } job_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

@@ rtl/zero_width_stego_encoder_unit.sv @@
// A transaction's first character passes through the job register and the serializer into m_char_reg.
// Throughput: one character per cycle while m_ready is high; a byte yields 0, 1, 2, 32, 33
// or 34 characters, about 11 on average, all sent through the single output serializer.
// A new byte is accepted every cycle while the job register has room.
// Reset: synchronous, active low on aresetn; clears message state, key registers and valids.
// ----------------------------------------------------------------------------
// Zero-width stego encoder
// XORs message bytes with a repeating key, Base64-encodes them and emits each
// Base64 character as eight zero-width UTF-8 characters, the message framed by two markers.
// ----------------------------------------------------------------------------
module zero_width_stego_encoder_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [zwse_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [zwse_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [zwse_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_last_byte,
    input  logic                            s_message_empty,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [23:0]                     m_utf8_char,
    output logic                            m_last_char
);

    logic [63:0]                    key_low_reg;
    logic [63:0]                    key_high_reg;
    logic [zwse_pkg::KEY_LEN_W-1:0] key_len_reg;
    logic [1:0]                     cfg_idx;
    logic                           cfg_wr;

    logic                           started_reg, started_next;
    logic [15:0]                    held_bytes_reg, held_bytes_next;
    logic [1:0]                     held_count_reg, held_count_next;
    logic [zwse_pkg::KEY_POS_W-1:0] key_pos_reg, key_pos_next;

    zwse_pkg::job_t                 job;
    logic                           job_empty;
    logic                           pend_valid_reg, pend_valid_next;
    zwse_pkg::job_t                 pend_reg, pend_next;

    logic                           act_start_reg, act_start_next;
    logic [31:0]                    act_bits_reg, act_bits_next;
    logic [5:0]                     act_cnt_reg, act_cnt_next;
    logic                           act_end_reg, act_end_next;

    logic                           m_valid_reg, m_valid_next;
    logic [23:0]                    m_char_reg, m_char_next;
    logic                           m_last_reg, m_last_next;

    logic                           out_free, act_busy, act_final, emit, load, accept;

    logic [zwse_pkg::KEY_LEN_W-1:0] klen;
    logic [zwse_pkg::KEY_POS_W-1:0] kpos_eff;
    logic [zwse_pkg::KEY_LEN_W-1:0] kpos_inc;
    logic [zwse_pkg::KEY_BITS-1:0]  key_all;
    logic [7:0]                     byte_x;
    logic [23:0]                    grp;
    logic                           closing;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            zwse_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            zwse_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            zwse_pkg::REG_KEY_LEN:  prdata = {{(zwse_pkg::CFG_DATA_W-zwse_pkg::KEY_LEN_W){1'b0}},
                                              key_len_reg};
            default:                prdata = '0;
        endcase
    end

    // Per-byte job: key XOR, Base64 grouping and end-of-message flush.
    always_comb begin
        key_all = {key_high_reg, key_low_reg};
        klen = (key_len_reg > zwse_pkg::KEY_LEN_W'(zwse_pkg::MAX_KEY_BYTES))
             ? zwse_pkg::KEY_LEN_W'(zwse_pkg::MAX_KEY_BYTES) : key_len_reg;
        kpos_eff = ({1'b0, key_pos_reg} >= klen) ? '0 : key_pos_reg;
        kpos_inc = {1'b0, kpos_eff} + zwse_pkg::KEY_LEN_W'(1);
        closing  = s_last_byte || s_message_empty;

        byte_x          = s_data_byte;
        key_pos_next    = key_pos_reg;
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        started_next    = 1'b1;
        grp             = '0;

        job.has_start = !started_reg;
        job.chars     = '0;
        job.nbits     = '0;
        job.has_end   = 1'b0;

        if (!s_message_empty) begin
            if (klen != '0) begin
                byte_x       = s_data_byte ^ key_all[{kpos_eff, 3'b000} +: 8];
                key_pos_next = (kpos_inc >= klen) ? '0 : kpos_inc[zwse_pkg::KEY_POS_W-1:0];
            end
            unique case (held_count_reg)
                2'd0: begin
                    held_bytes_next = {byte_x, 8'h00};
                    held_count_next = 2'd1;
                end
                2'd1: begin
                    held_bytes_next = {held_bytes_reg[15:8], byte_x};
                    held_count_next = 2'd2;
                end
                default: begin
                    grp = {held_bytes_reg, byte_x};
                    job.chars = {zwse_pkg::b64_char(grp[23:18]), zwse_pkg::b64_char(grp[17:12]),
                                 zwse_pkg::b64_char(grp[11:6]), zwse_pkg::b64_char(grp[5:0])};
                    job.nbits = 6'd32;
                    held_bytes_next = '0;
                    held_count_next = 2'd0;
                end
            endcase
        end

        if (closing) begin
            grp = {held_bytes_next, 8'h00};
            if (held_count_next == 2'd1) begin
                job.chars = {zwse_pkg::b64_char(grp[23:18]), zwse_pkg::b64_char(grp[17:12]),
                             zwse_pkg::PAD_CHAR, zwse_pkg::PAD_CHAR};
                job.nbits = 6'd32;
            end else if (held_count_next != 2'd0) begin
                job.chars = {zwse_pkg::b64_char(grp[23:18]), zwse_pkg::b64_char(grp[17:12]),
                             zwse_pkg::b64_char(grp[11:6]), zwse_pkg::PAD_CHAR};
                job.nbits = 6'd32;
            end
            job.has_end     = 1'b1;
            started_next    = 1'b0;
            held_bytes_next = '0;
            held_count_next = 2'd0;
            key_pos_next    = '0;
        end

        job_empty = !job.has_start && (job.nbits == '0) && !job.has_end;
    end

    // Handshake, job register and character serializer.
    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        act_busy  = act_start_reg || (act_cnt_reg != '0) || act_end_reg;
        act_final = (act_start_reg && (act_cnt_reg == '0) && !act_end_reg)
                 || (!act_start_reg && (act_cnt_reg == 6'd1) && !act_end_reg)
                 || (!act_start_reg && (act_cnt_reg == '0) && act_end_reg);
        emit      = out_free && act_busy;
        load      = pend_valid_reg && (!act_busy || (emit && act_final));
        s_ready   = !pend_valid_reg || load;
        accept    = s_valid && s_ready;

        act_start_next = act_start_reg;
        act_bits_next  = act_bits_reg;
        act_cnt_next   = act_cnt_reg;
        act_end_next   = act_end_reg;
        m_valid_next   = m_valid_reg;
        m_char_next    = m_char_reg;
        m_last_next    = m_last_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            m_last_next  = 1'b0;
            if (act_start_reg) begin
                m_char_next    = zwse_pkg::CH_START;
                act_start_next = 1'b0;
            end else if (act_cnt_reg != '0) begin
                m_char_next   = act_bits_reg[31] ? zwse_pkg::CH_ONE : zwse_pkg::CH_ZERO;
                act_bits_next = {act_bits_reg[30:0], 1'b0};
                act_cnt_next  = act_cnt_reg - 6'd1;
            end else begin
                m_char_next  = zwse_pkg::CH_END;
                m_last_next  = 1'b1;
                act_end_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (load) begin
            act_start_next = pend_reg.has_start;
            act_bits_next  = pend_reg.chars;
            act_cnt_next   = pend_reg.nbits;
            act_end_next   = pend_reg.has_end;
        end

        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (load) begin
            pend_valid_next = 1'b0;
        end
        if (accept && !job_empty) begin
            pend_next       = job;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_len_reg    <= '0;
            started_reg    <= 1'b0;
            held_bytes_reg <= '0;
            held_count_reg <= 2'd0;
            key_pos_reg    <= '0;
            pend_valid_reg <= 1'b0;
            act_start_reg  <= 1'b0;
            act_cnt_reg    <= '0;
            act_end_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    zwse_pkg::REG_KEY_LOW:  key_low_reg  <= pwdata;
                    zwse_pkg::REG_KEY_HIGH: key_high_reg <= pwdata;
                    zwse_pkg::REG_KEY_LEN:  key_len_reg  <= pwdata[zwse_pkg::KEY_LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                started_reg    <= started_next;
                held_bytes_reg <= held_bytes_next;
                held_count_reg <= held_count_next;
                key_pos_reg    <= key_pos_next;
            end
            pend_valid_reg <= pend_valid_next;
            act_start_reg  <= act_start_next;
            act_cnt_reg    <= act_cnt_next;
            act_end_reg    <= act_end_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_reg     <= pend_next;
        act_bits_reg <= act_bits_next;
        m_char_reg   <= m_char_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_utf8_char = m_char_reg;
    assign m_last_char = m_last_reg;

endmodule

@@ rtl/zwse_checker.sv @@
// ----------------------------------------------------------------------------
// Zero-width stego encoder port checker
// Watches the result channel of the encoder and flags illegal sequences.
// ----------------------------------------------------------------------------
module zwse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [23:0] m_utf8_char,
    input logic        m_last_char
);

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_utf8_char) && $stable(m_last_char);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    property p_char_set;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_utf8_char == zwse_pkg::CH_START) || (m_utf8_char == zwse_pkg::CH_END)
                 || (m_utf8_char == zwse_pkg::CH_ZERO) || (m_utf8_char == zwse_pkg::CH_ONE);
    endproperty
    a_char_set: assert property (p_char_set) else $error("unexpected character");

    property p_last_is_end;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_char == (m_utf8_char == zwse_pkg::CH_END));
    endproperty
    a_last_is_end: assert property (p_last_is_end) else $error("last flag not on end marker");

    property p_reset_clears;
        @(posedge aclk) !aresetn |=> !m_valid;
    endproperty
    a_reset_clears: assert property (p_reset_clears) else $error("valid after reset");

    property p_end_then_start;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_char ##1 m_valid |-> m_utf8_char == zwse_pkg::CH_START;
    endproperty
    a_end_then_start: assert property (p_end_then_start)
        else $error("message does not open with start marker");

endmodule

bind zero_width_stego_encoder_unit zwse_checker u_zwse_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_utf8_char (m_utf8_char),
    .m_last_char (m_last_char)
);
